### src/nir_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder package
// Decoder phase type, report kinds and the timing windows of the line code.
// ----------------------------------------------------------------------------
package nir_pkg;

  // Segment length and register widths
  localparam int unsigned DurW  = 17;
  localparam int unsigned WordW = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned BitsW = 5;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEADER,
    PH_REPEAT,
    PH_BITS
  } phase_t;

  // Report kinds
  typedef logic [KindW-1:0] kind_t;
  localparam kind_t KIND_FRAME  = 2'd0;
  localparam kind_t KIND_REPEAT = 2'd1;
  localparam kind_t KIND_NO_KEY = 2'd2;

  // Command stored when the line idles past the timeout
  localparam logic [WordW-1:0] NO_KEY_CODE = 16'hff00;

  // Reset value of the idle timeout register
  localparam logic [DurW-1:0] TIMEOUT_RESET = 17'd100000;

  // Open windows (bounds excluded), in microseconds
  localparam logic [DurW-1:0] LEADER_LO_MIN = 17'd8000;
  localparam logic [DurW-1:0] LEADER_LO_MAX = 17'd10000;
  localparam logic [DurW-1:0] START_HI_MIN  = 17'd4000;
  localparam logic [DurW-1:0] START_HI_MAX  = 17'd5000;
  localparam logic [DurW-1:0] RPT_HI_MIN    = 17'd2000;
  localparam logic [DurW-1:0] RPT_HI_MAX    = 17'd2500;
  localparam logic [DurW-1:0] RPT_LO_MIN    = 17'd500;
  localparam logic [DurW-1:0] RPT_LO_MAX    = 17'd700;
  localparam logic [DurW-1:0] BURST_MIN     = 17'd400;
  localparam logic [DurW-1:0] BURST_MAX     = 17'd700;
  localparam logic [DurW-1:0] ONE_HI_MIN    = 17'd1500;
  localparam logic [DurW-1:0] ONE_HI_MAX    = 17'd1800;

endpackage

### src/nec_ir_pulse_decoder_top.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder
// Decodes completed line segments (level, length in us) into NEC frame,
// repeat and no-key reports.
// ----------------------------------------------------------------------------
// Path: an accepted segment is held in the input register, then decoded
//   into the result register.
// Throughput: one segment per cycle unless m_axis_tready holds back a report;
//   the input and result registers advance together when the result is free or taken.
// Reset (rst, synchronous): phase idle, held words zero, timeout 100000 us.
module nec_ir_pulse_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // Timeout register
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  // Segment stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [16:0] duration_us, [23:17] zero
  input  logic        s_axis_tuser,   // [0] level
  // Report stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] address, [31:16] command
  output logic [1:0]  m_axis_tuser    // [1:0] report_kind
);

  localparam int unsigned DurW  = nir_pkg::DurW;
  localparam int unsigned WordW = nir_pkg::WordW;
  localparam int unsigned BitsW = nir_pkg::BitsW;

  // Registers
  logic                 in_valid;
  logic                 in_level;
  logic [DurW-1:0]      in_dur;
  logic                 out_valid;
  logic [WordW-1:0]     out_address;
  logic [WordW-1:0]     out_command;
  nir_pkg::kind_t       out_kind;
  logic [DurW-1:0]      idle_timeout_us;
  nir_pkg::phase_t      phase;
  logic [BitsW-1:0]     bit_count;
  logic                 burst_ok;
  logic [WordW-1:0]     held_address;
  logic [WordW-1:0]     held_command;

  // Next values and decode
  nir_pkg::phase_t      phase_next;
  logic [BitsW-1:0]     bit_count_next;
  logic                 burst_ok_next;
  logic [WordW-1:0]     held_address_next;
  logic [WordW-1:0]     held_command_next;
  logic                 emit;
  nir_pkg::kind_t       emit_kind;
  logic                 advance;
  logic                 win_leader;
  logic                 win_start;
  logic                 win_rpt_hi;
  logic                 win_rpt_lo;
  logic                 win_burst;
  logic                 win_one;
  logic                 timed_out;
  logic                 bit_one;
  logic [WordW-1:0]     bit_mask;

  // Handshake: the pipe moves when the result register can take a word
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_command, out_address};
  assign m_axis_tuser  = out_kind;

  // Timing windows on the registered segment
  assign win_leader = (in_dur > nir_pkg::LEADER_LO_MIN) && (in_dur < nir_pkg::LEADER_LO_MAX);
  assign win_start  = (in_dur > nir_pkg::START_HI_MIN)  && (in_dur < nir_pkg::START_HI_MAX);
  assign win_rpt_hi = (in_dur > nir_pkg::RPT_HI_MIN)    && (in_dur < nir_pkg::RPT_HI_MAX);
  assign win_rpt_lo = (in_dur > nir_pkg::RPT_LO_MIN)    && (in_dur < nir_pkg::RPT_LO_MAX);
  assign win_burst  = (in_dur > nir_pkg::BURST_MIN)     && (in_dur < nir_pkg::BURST_MAX);
  assign win_one    = (in_dur > nir_pkg::ONE_HI_MIN)    && (in_dur < nir_pkg::ONE_HI_MAX);
  assign timed_out  = in_dur > idle_timeout_us;
  assign bit_one    = burst_ok && win_one;
  assign bit_mask   = {{(WordW-1){1'b0}}, bit_one} << bit_count[3:0];

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      nir_pkg::PH_LEADER: begin
        if (!in_level) begin
          phase_next = win_leader ? nir_pkg::PH_LEADER : nir_pkg::PH_IDLE;
        end else if (win_start) begin
          phase_next = nir_pkg::PH_BITS;
        end else if (win_rpt_hi) begin
          phase_next = nir_pkg::PH_REPEAT;
        end else begin
          phase_next = nir_pkg::PH_IDLE;
        end
      end
      nir_pkg::PH_REPEAT: begin
        phase_next = nir_pkg::PH_IDLE;
      end
      nir_pkg::PH_BITS: begin
        if (in_level && (bit_count == {BitsW{1'b1}})) begin
          phase_next = nir_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = (!in_level && win_leader) ? nir_pkg::PH_LEADER : nir_pkg::PH_IDLE;
      end
    endcase
  end

  // Frame data and report decode
  always_comb begin
    bit_count_next    = bit_count;
    burst_ok_next     = burst_ok;
    held_address_next = held_address;
    held_command_next = held_command;
    emit              = 1'b0;
    emit_kind         = nir_pkg::KIND_FRAME;
    case (phase)
      nir_pkg::PH_LEADER: begin
        if (in_level && win_start) begin
          bit_count_next    = '0;
          burst_ok_next     = 1'b0;
          held_address_next = '0;
          held_command_next = '0;
        end
      end
      nir_pkg::PH_REPEAT: begin
        if (in_level) begin
          if (timed_out) begin
            held_command_next = nir_pkg::NO_KEY_CODE;
            emit              = 1'b1;
            emit_kind         = nir_pkg::KIND_NO_KEY;
          end
        end else if (win_rpt_lo) begin
          emit      = 1'b1;
          emit_kind = nir_pkg::KIND_REPEAT;
        end
      end
      nir_pkg::PH_BITS: begin
        if (!in_level) begin
          burst_ok_next = win_burst;
        end else begin
          if (bit_count[BitsW-1]) begin
            held_command_next = held_command | bit_mask;
          end else begin
            held_address_next = held_address | bit_mask;
          end
          burst_ok_next  = 1'b0;
          bit_count_next = bit_count + 1'b1;
          if (bit_count == {BitsW{1'b1}}) begin
            emit      = 1'b1;
            emit_kind = nir_pkg::KIND_FRAME;
          end
        end
      end
      default: begin
        if (in_level && timed_out) begin
          held_command_next = nir_pkg::NO_KEY_CODE;
          emit              = 1'b1;
          emit_kind         = nir_pkg::KIND_NO_KEY;
        end
      end
    endcase
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_us <= nir_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      idle_timeout_us <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level <= s_axis_tuser;
      in_dur   <= s_axis_tdata[DurW-1:0];
    end
  end

  // Decoder state: advance on each segment leaving the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= nir_pkg::PH_IDLE;
      bit_count    <= '0;
      burst_ok     <= 1'b0;
      held_address <= '0;
      held_command <= '0;
    end else if (in_valid && advance) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      burst_ok     <= burst_ok_next;
      held_address <= held_address_next;
      held_command <= held_command_next;
    end
  end

  // Result register: load a report, drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && emit) begin
      out_address <= held_address_next;
      out_command <= held_command_next;
      out_kind    <= emit_kind;
    end
  end

  // Checks
  a_count_only_in_frame: assert property (@(posedge clk) disable iff (rst)
    (phase != nir_pkg::PH_BITS) |-> (bit_count == '0))
    else $error("bit count left non-zero outside a frame");

  a_no_key_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == nir_pkg::KIND_NO_KEY)) |-> (out_command == nir_pkg::NO_KEY_CODE))
    else $error("no-key report without the no-key command");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == nir_pkg::KIND_FRAME || out_kind == nir_pkg::KIND_REPEAT
                   || out_kind == nir_pkg::KIND_NO_KEY))
    else $error("report kind out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled without a blocked result");

endmodule
